// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl file bba_engine
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== hdl/bba_pkg.sv =====
// types and constants for the buddy block allocator
// no dependencies
`default_nettype none
package bba_pkg;
  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_RESIZE = 2'd2;
  localparam logic [1:0] FUNC_RESET  = 2'd3;

  localparam logic [1:0] ST_BLOCK  = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_NOMEM  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic REG_SHIFT  = 1'b0;
  localparam logic REG_LEVELS = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] request_bytes;
    logic [31:0] block_offset_in;
    logic        no_block;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [25:0] block_offset_out;
    logic        must_copy;
    logic [26:0] copy_bytes;
  } rsp_t;
endpackage
`default_nettype wire

// ===== hdl/bba_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/bba_engine.sv =====
// sequencer that runs allocate, free, resize and pool reset on the two memories
// depends on bba_pkg, bba_ram, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module bba_engine #(
  parameter int NUM_LEVELS = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [4:0]    cfg_shift,
  input  wire logic [3:0]    cfg_levels,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bba_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output bba_pkg::rsp_t      rsp
);
  import bba_pkg::*;
  localparam int TOP = NUM_LEVELS - 1;
  localparam int MAP_DEPTH = (1 << NUM_LEVELS) - 1;
  localparam int TAB_DEPTH = 1 << TOP;
  localparam int MAW = $clog2(MAP_DEPTH);
  localparam int TAW = $clog2(TAB_DEPTH) > 0 ? $clog2(TAB_DEPTH) : 1;
  localparam int LW = $clog2(NUM_LEVELS + 1);
  localparam int IW = TOP + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_SIZE, S_A_SCAN, S_A_SCANW, S_A_SPLIT, S_A_DONE,
    S_F_LOOK, S_F_LOOKW, S_F_BUD, S_F_BUDW, S_F_MERGE, S_F_DONE, S_R_LOOKW,
    S_OUT
  } state_t;

  state_t state;
  req_t   r;
  logic [4:0]  shift;
  logic [3:0]  levels;
  logic [LW-1:0] want, lvl;
  logic [IW-1:0] idx;
  logic [MAW:0]  clr;
  logic [5:0]    size_lg;
  logic [31:0]   off_al;
  logic [TAW-1:0] tidx;
  logic          resize_move;
  logic [25:0]   new_off;
  logic [26:0]   cur_bytes;
  logic [1:0]    st;

  logic           m_we, m_wd, m_rd;
  logic [MAW-1:0] m_wa, m_ra;
  logic           t_we;
  logic [TAW-1:0] t_wa, t_ra;
  logic [3:0]     t_wd, t_rd;

  bba_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  bba_ram #(.WIDTH(4), .DEPTH(TAB_DEPTH)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

  function automatic logic [MAW-1:0] map_pos(input logic [LW-1:0] l, input logic [IW-1:0] i);
    logic [MAW:0] base;
    logic [IW-1:0] mask;
    base = (MAW+1)'((1 << NUM_LEVELS) - (1 << (NUM_LEVELS - int'(l))));
    mask = IW'((1 << (TOP - int'(l))) - 1);
    return MAW'(base + (MAW+1)'(i & mask));
  endfunction

  logic [37:0] pool_bytes;
  logic        off_out_of_pool;
  logic [31:0] free_cnt_top;
  assign pool_bytes = 38'd1 << (levels + shift);
  assign off_out_of_pool = {6'd0, off_al} >= pool_bytes;
  assign free_cnt_top = 32'd1 << (levels - 4'(lvl));
  assign tidx = TAW'(off_al >> shift);

  always_comb begin
    m_we = 1'b0; m_wa = '0; m_wd = 1'b0; m_ra = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = tidx;
    unique case (state)
      S_CLEAR: begin
        m_we = 1'b1; m_wa = MAW'(clr);
        m_wd = (MAW'(clr) == map_pos(LW'(levels), '0));
        t_we = 1'b1; t_wa = TAW'(clr);
      end
      S_A_SCAN: m_ra = map_pos(lvl, idx);
      S_A_SCANW: begin
        m_we = m_rd; m_wa = map_pos(lvl, idx); m_wd = 1'b0;
      end
      S_A_SPLIT: begin
        m_we = 1'b1;
        m_wa = (lvl == want) ? map_pos(lvl, idx) : map_pos(lvl - 1'b1, {idx[IW-2:0], 1'b1});
        m_wd = (lvl != want);
      end
      S_A_DONE: begin
        t_we = 1'b1; t_wa = TAW'(idx << want); t_wd = 4'(want + 1'b1);
      end
      S_F_LOOK: t_ra = tidx;
      S_F_BUD: m_ra = map_pos(lvl, idx ^ IW'(1));
      S_F_MERGE: begin
        m_we = 1'b1; m_wa = map_pos(lvl, idx ^ IW'(1)); m_wd = 1'b0;
      end
      S_F_DONE: begin
        m_we = 1'b1; m_wa = map_pos(lvl, idx); m_wd = 1'b1;
        t_we = 1'b1; t_wa = tidx; t_wd = '0;
      end
      default: ;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      rsp_valid <= 1'b0;
      shift <= 5'd4;
      levels <= 4'(TOP < 10 ? TOP : 10);
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (MAW+1)'(MAP_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req_valid) begin
          r <= req;
          off_al <= (req.block_offset_in >> shift) << shift;
          st <= ST_DONE; resize_move <= 1'b0; new_off <= '0;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          want <= '0; size_lg <= 6'(shift);
          unique case (r.func)
            FUNC_ALLOC: state <= (r.request_bytes == 0) ? S_OUT : S_A_SIZE;
            FUNC_FREE: state <= r.no_block ? S_OUT : S_F_LOOK;
            FUNC_RESIZE: begin
              if (r.no_block) state <= (r.request_bytes == 0) ? S_OUT : S_A_SIZE;
              else if (r.request_bytes == 0) state <= S_F_LOOK;
              else if (off_out_of_pool) begin st <= ST_REJECT; state <= S_OUT; end
              else state <= S_R_LOOKW;
            end
            default: begin
              shift <= (cfg_shift < 5'd3) ? 5'd3 : (cfg_shift > 5'd16 ? 5'd16 : cfg_shift);
              levels <= (int'(cfg_levels) > TOP) ? 4'(TOP) : cfg_levels;
              clr <= '0; st <= ST_DONE; state <= S_OUT;
            end
          endcase
        end
        S_R_LOOKW: begin
          if (t_rd == 0) begin st <= ST_REJECT; state <= S_OUT; end
          else if ({6'd0, r.request_bytes} <= (38'd1 << (shift + t_rd - 1'b1))) begin
            st <= ST_BLOCK; new_off <= off_al[25:0]; state <= S_OUT;
          end else begin
            resize_move <= 1'b1;
            cur_bytes <= 27'(38'd1 << (shift + t_rd - 1'b1));
            state <= S_A_SIZE;
          end
        end
        S_A_SIZE: begin
          if ((38'd1 << size_lg) >= {6'd0, r.request_bytes}) begin
            if (want > LW'(levels)) begin st <= ST_NOMEM; state <= S_OUT; end
            else begin lvl <= want; idx <= '0; state <= S_A_SCAN; end
          end else begin
            size_lg <= size_lg + 1'b1; want <= want + 1'b1;
            if (want > LW'(levels)) begin st <= ST_NOMEM; state <= S_OUT; end
          end
        end
        S_A_SCAN: state <= S_A_SCANW;
        S_A_SCANW: begin
          if (m_rd) state <= S_A_SPLIT;
          else if (32'(idx) + 1 < free_cnt_top) begin idx <= idx + 1'b1; state <= S_A_SCAN; end
          else if (lvl < LW'(levels)) begin lvl <= lvl + 1'b1; idx <= '0; state <= S_A_SCAN; end
          else begin st <= ST_NOMEM; state <= S_OUT; end
        end
        S_A_SPLIT: begin
          if (lvl == want) state <= S_A_DONE;
          else begin lvl <= lvl - 1'b1; idx <= {idx[IW-2:0], 1'b0}; end
        end
        S_A_DONE: begin
          st <= ST_BLOCK;
          new_off <= 26'(({6'd0, idx} << want) << shift);
          state <= resize_move ? S_F_LOOK : S_OUT;
        end
        S_F_LOOK: begin
          if (off_out_of_pool) begin
            if (!resize_move) st <= ST_REJECT;
            state <= S_OUT;
          end else state <= S_F_LOOKW;
        end
        S_F_LOOKW: begin
          if (t_rd == 0) begin
            if (!resize_move) st <= ST_REJECT;
            state <= S_OUT;
          end else begin
            lvl <= (LW'(t_rd - 1'b1) > LW'(levels)) ? LW'(levels) : LW'(t_rd - 1'b1);
            idx <= IW'(tidx >> (t_rd - 1'b1));
            state <= S_F_BUD;
          end
        end
        S_F_BUD: state <= (lvl < LW'(levels)) ? S_F_BUDW : S_F_DONE;
        S_F_BUDW: state <= m_rd ? S_F_MERGE : S_F_DONE;
        S_F_MERGE: begin
          idx <= idx >> 1; lvl <= lvl + 1'b1; state <= S_F_BUD;
        end
        S_F_DONE: begin
          if (!resize_move) st <= ST_DONE;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp.status <= st;
            rsp.block_offset_out <= (st == ST_BLOCK) ? new_off : '0;
            rsp.must_copy <= (st == ST_BLOCK) && resize_move;
            rsp.copy_bytes <= (st == ST_BLOCK && resize_move) ? cur_bytes : '0;
            state <= (r.func == FUNC_RESET) ? S_CLEAR : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rsp_valid && rsp_ready && !(state == S_OUT))
        rsp_valid <= 1'b0;
    end
  end

  `ASSERT_NEVER(a_clear_busy, clk, rst, (state == S_CLEAR) && req_ready, "ready during clear")
  `ASSERT_NEVER(a_scan_range, clk, rst, (state == S_A_SCAN) && (lvl > LW'(levels)),
    "scan above pool level")
  `ASSERT_IMPL(a_tab_ok, clk, rst, (t_we && state == S_A_DONE) |-> (t_wd != 0),
    "allocate wrote empty level")
  `ASSERT_IMPL(a_move, clk, rst, (rsp_valid && rsp.must_copy) |-> (rsp.status == ST_BLOCK),
    "copy without block")
endmodule
`default_nettype wire

// ===== hdl/buddy_block_allocator.sv =====
// buddy block allocator top level: stream ports, config registers, engine
// depends on bba_pkg, bba_engine
`default_nettype none
// Buddy allocator over a pool of 2^pool_levels minimum blocks; free bits and block levels
// live in two synchronous RAMs with registered read. One beat in gives one beat out. A
// beat that needs no lookup (zero-size allocate, null free) goes from dispatch straight
// to the result; otherwise the engine scans the free bits one at a time, splits the
// block found down to the wanted level, or merges a freed block with its free buddies;
// the free-bitmap read port sets the pace. After rst and after the result of a pool
// reset beat a clearing pass over all 2^NUM_LEVELS-1 free-bitmap entries runs before
// the next beat is taken. Register writes take effect at the next pool reset.
module buddy_block_allocator #(
  parameter int NUM_LEVELS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // request_bytes, block_offset_in
  input  wire logic [2:0]  s_tuser,   // func, no_block
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // status, block_offset_out, must_copy, copy_bytes
);
  import bba_pkg::*;
  logic [4:0] min_block_shift;
  logic [3:0] pool_levels;
  req_t req;
  rsp_t rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_block_shift <= 5'd4;
      pool_levels <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHIFT:  min_block_shift <= cfg_data;
        REG_LEVELS: pool_levels <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign req = '{func: s_tuser[1:0], request_bytes: s_tdata[31:0],
                 block_offset_in: s_tdata[63:32], no_block: s_tuser[2]};

  bba_engine #(.NUM_LEVELS(NUM_LEVELS)) u_engine (
    .clk(clk), .rst(rst), .cfg_shift(min_block_shift), .cfg_levels(pool_levels),
    .req_valid(s_tvalid), .req_ready(s_tready), .req(req),
    .rsp_valid(m_tvalid), .rsp_ready(m_tready), .rsp(rsp));

  assign m_tdata = {rsp.copy_bytes, rsp.must_copy, rsp.block_offset_out, rsp.status};
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for the buddy block allocator: directed and random alloc/free/resize/reset beats
// checked against an in-bench allocator model; depends on bba_pkg and buddy_block_allocator
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import bba_pkg::*;

  localparam int LEVELS = 11;
  localparam int TOP = LEVELS - 1;
  localparam int MAP_SIZE = (1 << LEVELS) - 1;
  localparam int TAB_SIZE = 1 << TOP;
  localparam int IDLE_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;  // request_bytes, block_offset_in
  logic [2:0] s_tuser = '0;   // func, no_block
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;       // status, block_offset_out, must_copy, copy_bytes

  buddy_block_allocator #(.NUM_LEVELS(LEVELS)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  longint unsigned live_blocks[$];
  int errors = 0;
  bit calm = 1'b0;
  bit s_fire = 1'b0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int idle_cycles = 0;

  // allocator model state
  bit free_bits[MAP_SIZE];
  logic [3:0] level_tab[TAB_SIZE];
  int unsigned shift_reg = 4, levels_reg = 10;
  int unsigned pool_shift, pool_lvls;

  function automatic int unsigned map_idx(int unsigned lvl, int unsigned idx);
    return (1 << LEVELS) - (1 << (LEVELS - lvl)) + (idx & ((1 << (TOP - lvl)) - 1));
  endfunction

  function automatic void clear_pool();
    pool_shift = shift_reg < 3 ? 3 : (shift_reg > 16 ? 16 : shift_reg);
    pool_lvls = levels_reg > TOP ? TOP : levels_reg;
    foreach (free_bits[i]) free_bits[i] = 1'b0;
    foreach (level_tab[i]) level_tab[i] = '0;
    free_bits[map_idx(pool_lvls, 0)] = 1'b1;
  endfunction

  function automatic logic [1:0] take_block(longint unsigned need, output longint unsigned off);
    longint unsigned size;
    int unsigned want, lvl, idx;
    bit found;
    off = 0;
    if (need == 0) return ST_DONE;
    size = 64'd1 << pool_shift;
    want = 0;
    found = 1'b0;
    idx = 0;
    while (size < need) begin
      size <<= 1;
      want++;
    end
    if (want > pool_lvls) return ST_NOMEM;
    for (lvl = want; lvl <= pool_lvls && !found; lvl++) begin
      for (idx = 0; idx < (1 << (pool_lvls - lvl)); idx++) begin
        if (free_bits[map_idx(lvl, idx)]) begin
          found = 1'b1;
          break;
        end
      end
      if (found) break;
    end
    if (!found) return ST_NOMEM;
    free_bits[map_idx(lvl, idx)] = 1'b0;
    while (lvl > want) begin
      lvl--;
      idx <<= 1;
      free_bits[map_idx(lvl, idx + 1)] = 1'b1;
    end
    idx <<= want;
    level_tab[idx & (TAB_SIZE - 1)] = 4'(want + 1);
    off = longint'(idx) << pool_shift;
    return ST_BLOCK;
  endfunction

  function automatic logic [1:0] release_block(longint unsigned offset);
    int unsigned slot, lvl, idx, bp;
    if (offset >= (64'd1 << (pool_lvls + pool_shift))) return ST_REJECT;
    slot = 32'((offset >> pool_shift) & (TAB_SIZE - 1));
    if (level_tab[slot] == 0) return ST_REJECT;
    lvl = level_tab[slot] - 1;
    level_tab[slot] = '0;
    if (lvl > pool_lvls) lvl = pool_lvls;
    idx = slot >> lvl;
    while (lvl < pool_lvls) begin
      bp = map_idx(lvl, idx ^ 1);
      if (!free_bits[bp]) break;
      free_bits[bp] = 1'b0;
      idx >>= 1;
      lvl++;
    end
    free_bits[map_idx(lvl, idx)] = 1'b1;
    return ST_DONE;
  endfunction

  function automatic void drop_live(longint unsigned off);
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == off) begin
        live_blocks.delete(i);
        return;
      end
    end
  endfunction

  // predicts the response for one request and keeps the live block list current
  function automatic rsp_t alloc_result(req_t r);
    rsp_t rsp;
    longint unsigned offset, req, new_off, cur;
    int unsigned slot;
    rsp = '0;
    new_off = 0;
    cur = 0;
    req = r.request_bytes;
    offset = (64'(r.block_offset_in) >> pool_shift) << pool_shift;
    case (r.func)
      FUNC_ALLOC: rsp.status = take_block(req, new_off);
      FUNC_FREE: begin
        rsp.status = r.no_block ? ST_DONE : release_block(offset);
        if (!r.no_block && rsp.status == ST_DONE) drop_live(offset);
      end
      FUNC_RESIZE: begin
        if (r.no_block) rsp.status = take_block(req, new_off);
        else if (req == 0) begin
          rsp.status = release_block(offset);
          if (rsp.status == ST_DONE) drop_live(offset);
        end else if (offset >= (64'd1 << (pool_lvls + pool_shift))) rsp.status = ST_REJECT;
        else begin
          slot = 32'((offset >> pool_shift) & (TAB_SIZE - 1));
          if (level_tab[slot] == 0) rsp.status = ST_REJECT;
          else begin
            cur = 64'd1 << (pool_shift + level_tab[slot] - 1);
            if (req <= cur) begin
              rsp.status = ST_BLOCK;
              new_off = offset;
            end else begin
              rsp.status = take_block(req, new_off);
              if (rsp.status == ST_BLOCK) begin
                rsp.must_copy = 1'b1;
                rsp.copy_bytes = 27'(cur);
                void'(release_block(offset));
                drop_live(offset);
                live_blocks.push_back(new_off);
              end
            end
          end
        end
      end
      default: begin
        clear_pool();
        live_blocks.delete();
        rsp.status = ST_DONE;
      end
    endcase
    if (rsp.status == ST_BLOCK) begin
      rsp.block_offset_out = 26'(new_off);
      if ((r.func == FUNC_ALLOC || (r.func == FUNC_RESIZE && r.no_block))) live_blocks.push_back(new_off);
    end else begin
      rsp.must_copy = 1'b0;
      rsp.copy_bytes = '0;
    end
    return rsp;
  endfunction

  task automatic queue_req(logic [1:0] f, logic [31:0] req, logic [31:0] off, logic nul);
    req_t r;
    r.func = f;
    r.request_bytes = req;
    r.block_offset_in = off;
    r.no_block = nul;
    pending_reqs.push_back(r);
    expected_rsps.push_back(alloc_result(r));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_fire) begin
      s_tvalid <= 1'b1;
    end else if (gap_cnt > 0) begin
      s_tvalid <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else if (pending_reqs.size() != 0) begin
      s_tdata <= {pending_reqs[0].block_offset_in, pending_reqs[0].request_bytes};
      s_tuser <= {pending_reqs[0].no_block, pending_reqs[0].func};
      void'(pending_reqs.pop_front());
      s_tvalid <= 1'b1;
      gap_cnt <= pick_gap();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      m_tready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_cnt <= pick_gap();
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    rsp_t want, got;
    s_fire <= s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.block_offset_out = m_tdata[27:2];
      got.must_copy = m_tdata[28];
      got.copy_bytes = m_tdata[55:29];
      if (expected_rsps.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          errors++;
        end
        if (got.block_offset_out != want.block_offset_out) begin
          $error("block_offset_out expected %h actual %h", want.block_offset_out,
                 got.block_offset_out);
          errors++;
        end
        if (got.must_copy != want.must_copy) begin
          $error("must_copy expected %0d actual %0d", want.must_copy, got.must_copy);
          errors++;
        end
        if (got.copy_bytes != want.copy_bytes) begin
          $error("copy_bytes expected %h actual %h", want.copy_bytes, got.copy_bytes);
          errors++;
        end
      end
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SHIFT) shift_reg = val;
    else levels_reg = val & 4'hf;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || s_tvalid) @(posedge clk);
  endtask

  task automatic random_reqs(int n);
    int r;
    int unsigned lv;
    logic [31:0] req, off;
    longint unsigned hi, lo;
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      f = r < 40 ? FUNC_ALLOC : (r < 70 ? FUNC_FREE : (r < 98 ? FUNC_RESIZE : FUNC_RESET));
      r = $urandom_range(0, 99);
      if (r < 5) req = 0;
      else if (r < 12) req = $urandom;
      else begin
        lv = $urandom_range(0, pool_lvls + 1);
        hi = 64'd1 << (pool_shift + lv);
        lo = lv == 0 ? 0 : hi / 2;
        req = 32'($urandom_range(32'(hi), 32'(lo + 1)));
      end
      if (live_blocks.size() != 0 && $urandom_range(0, 99) < 80) begin
        off = 32'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
        if ($urandom_range(0, 4) == 0) off = off + $urandom_range(0, (1 << pool_shift) - 1);
      end else begin
        off = $urandom;
      end
      queue_req(f, req, off, $urandom_range(0, 99) < 8);
    end
  endtask

  initial begin
    int shifts[6];
    int lvls[6];
    shifts = '{4, 3, 16, 31, 0, 0};
    lvls = '{10, 0, 10, 15, 3, 0};
    shifts[5] = $urandom_range(0, 31);
    lvls[5] = $urandom_range(0, 15);
    clear_pool();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: default pool of 1024 blocks of 16 bytes
    queue_req(FUNC_ALLOC, 0, 0, 0);
    queue_req(FUNC_ALLOC, 32'hffff_ffff, 0, 0);
    queue_req(FUNC_ALLOC, 1, 0, 0);
    queue_req(FUNC_ALLOC, 16, 0, 0);
    queue_req(FUNC_ALLOC, 17, 0, 0);
    queue_req(FUNC_ALLOC, 16384, 0, 0);
    queue_req(FUNC_FREE, 0, 32'h40, 1);
    queue_req(FUNC_FREE, 0, 32'h5, 0);
    queue_req(FUNC_FREE, 0, 32'hffff_fff0, 0);
    queue_req(FUNC_FREE, 0, 32'h100, 0);
    queue_req(FUNC_RESIZE, 100, 0, 1);
    queue_req(FUNC_RESIZE, 32, 32'h20, 0);
    queue_req(FUNC_RESIZE, 200, 32'h10, 0);
    queue_req(FUNC_RESIZE, 32'h8000_0000, 32'h20, 0);
    queue_req(FUNC_RESIZE, 0, 32'h20, 0);
    queue_req(FUNC_RESIZE, 8, 32'h300, 0);
    queue_req(FUNC_RESIZE, 8, 32'hffff_ffff, 0);
    queue_req(FUNC_RESET, 0, 0, 0);
    queue_req(FUNC_ALLOC, 16384, 0, 0);
    queue_req(FUNC_ALLOC, 1, 0, 0);
    queue_req(FUNC_RESIZE, 16384, 32'hf, 0);
    queue_req(FUNC_FREE, 0, 0, 0);
    queue_req(FUNC_ALLOC, 16385, 0, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      calm = (p == 1 || p == 4);
      write_reg(REG_SHIFT, 5'(shifts[p]));
      write_reg(REG_LEVELS, 5'(lvls[p]));
      queue_req(FUNC_RESET, 0, 0, 0);
      random_reqs(120);
      drain();
      random_reqs(120);
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== buddy_block_allocator.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_engine.sv
hdl/buddy_block_allocator.sv
verif/tb_top.sv
